### rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds the channel payload structs, command and state codes, and the
// controller/datapath command and status bundles. No dependencies.
`default_nettype none

package tcw_pkg;

  // Default geometry of the character store
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Character and attribute constants
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  // Linear position width (covers 32 rows x 128 columns)
  localparam int POS_W = 12;

  // Register port
  localparam int         PADDR_W        = 3;
  localparam logic [0:0] REG_TEXT_COLOR = 1'b0;

  // Commands carried on the request channel
  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SET   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // Request transaction payload
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] col;
  } req_t;

  // Response transaction payload
  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
  } rsp_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_CLEAR,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL,
    ST_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic init_wr;
    logic clr_wr;
    logic scr_rd;
    logic scr_wr;
    logic fill_wr;
    logic load_out;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t item_cmd;
    logic ovf;
    logic cnt_end_all;
    logic cnt_end_copy;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/tcw_ctrl.sv
// Controller state machine for the text console writer.
// Sequences capture, execute, store sweeps and response loading.
// Depends on tcw_pkg.
`default_nettype none

module tcw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire tcw_pkg::sts_t sts,
  output tcw_pkg::ctl_t      ctl
);

  tcw_pkg::state_t state;
  tcw_pkg::state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        if (sts.cnt_end_all) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (req_valid) state_next = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        unique case (sts.item_cmd)
          tcw_pkg::CMD_PUT: begin
            if (sts.ovf) state_next = tcw_pkg::ST_SCROLL_RD;
            else state_next = sts.out_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_RESP;
          end
          tcw_pkg::CMD_CLEAR: state_next = tcw_pkg::ST_CLEAR;
          tcw_pkg::CMD_READ:  state_next = tcw_pkg::ST_RD_WAIT;
          default: state_next = sts.out_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_RESP;
        endcase
      end
      tcw_pkg::ST_RD_WAIT: begin
        state_next = sts.out_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_RESP;
      end
      tcw_pkg::ST_CLEAR, tcw_pkg::ST_FILL: begin
        if (sts.cnt_end_all) begin
          state_next = sts.out_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_RESP;
        end
      end
      tcw_pkg::ST_SCROLL_RD: state_next = tcw_pkg::ST_SCROLL_WR;
      tcw_pkg::ST_SCROLL_WR: begin
        state_next = sts.cnt_end_copy ? tcw_pkg::ST_FILL : tcw_pkg::ST_SCROLL_RD;
      end
      tcw_pkg::ST_RESP: begin
        if (sts.out_free) state_next = tcw_pkg::ST_IDLE;
      end
      default: state_next = tcw_pkg::ST_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    ctl       = '0;
    req_stall = 1'b1;
    unique case (state)
      tcw_pkg::ST_INIT: ctl.init_wr = 1'b1;
      tcw_pkg::ST_IDLE: begin
        req_stall   = 1'b0;
        ctl.capture = req_valid;
      end
      tcw_pkg::ST_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.item_cmd == tcw_pkg::CMD_SET
            || (sts.item_cmd == tcw_pkg::CMD_PUT && !sts.ovf)) begin
          ctl.load_out = sts.out_free;
        end
      end
      tcw_pkg::ST_RD_WAIT: ctl.load_out = sts.out_free;
      tcw_pkg::ST_CLEAR: begin
        ctl.clr_wr   = 1'b1;
        ctl.load_out = sts.cnt_end_all && sts.out_free;
      end
      tcw_pkg::ST_SCROLL_RD: ctl.scr_rd = 1'b1;
      tcw_pkg::ST_SCROLL_WR: ctl.scr_wr = 1'b1;
      tcw_pkg::ST_FILL: begin
        ctl.fill_wr  = 1'b1;
        ctl.load_out = sts.cnt_end_all && sts.out_free;
      end
      tcw_pkg::ST_RESP: ctl.load_out = sts.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/tcw_dp.sv
// Datapath for the text console writer: cell store, cursor, sweep counter,
// text color register with its register port, and the response register.
// Depends on tcw_pkg.
`default_nettype none

module tcw_dp #(
  parameter int SCREEN_COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tcw_pkg::req_t               req_data,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output tcw_pkg::rsp_t                    rsp_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire tcw_pkg::ctl_t               ctl,
  output tcw_pkg::sts_t                    sts
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int COPY_COUNT = SCREEN_COLUMNS * (SCREEN_ROWS - 1);
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  localparam logic [ADDR_W-1:0]         LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0]         COPY_LAST = ADDR_W'(COPY_COUNT - 1);
  localparam logic [ADDR_W-1:0]         ROW_STEP  = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [4:0]                LAST_ROW  = 5'(SCREEN_ROWS - 1);
  localparam logic [6:0]                LAST_COL  = 7'(SCREEN_COLUMNS - 1);
  localparam logic [tcw_pkg::POS_W-1:0] COLS_POS  = tcw_pkg::POS_W'(SCREEN_COLUMNS);

  // Item registers
  tcw_pkg::cmd_t item_cmd;
  logic [7:0]    item_char;
  logic [4:0]    item_row;
  logic [6:0]    item_col;

  // Cursor and configuration
  logic [4:0] cur_row;
  logic [6:0] cur_col;
  logic [4:0] row_next;
  logic [6:0] col_next;
  logic [7:0] text_color;

  // Store and sweep
  logic [15:0]       screen [CELL_COUNT];
  logic [15:0]       rdata;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0]       wr_cell;
  logic              wr_en;
  logic              put_wr;
  logic              row_inc;
  logic              ovf;
  logic              sweep_wr;
  logic              cfg_wr;

  logic [tcw_pkg::POS_W-1:0] pos_next;
  logic [tcw_pkg::POS_W-1:0] cur_pos;
  logic [tcw_pkg::POS_W-1:0] item_pos;

  // Linear positions of the cursor and of the item's cell
  assign pos_next = tcw_pkg::POS_W'({7'd0, row_next} * COLS_POS)
                  + {5'd0, col_next};
  assign cur_pos  = tcw_pkg::POS_W'({7'd0, cur_row} * COLS_POS) + {5'd0, cur_col};
  assign item_pos = tcw_pkg::POS_W'({7'd0, item_row} * COLS_POS) + {5'd0, item_col};

  // Capture the item, saturating the position
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_cmd  <= tcw_pkg::cmd_t'(req_data.cmd);
      item_char <= req_data.char_code;
      item_row  <= (req_data.row > LAST_ROW) ? LAST_ROW : req_data.row;
      item_col  <= (req_data.col > LAST_COL) ? LAST_COL : req_data.col;
    end
  end

  // Work out the cursor after the item
  always_comb begin
    row_next = cur_row;
    col_next = cur_col;
    put_wr   = 1'b0;
    row_inc  = 1'b0;
    ovf      = 1'b0;
    if (ctl.exec) begin
      case (item_cmd)
        tcw_pkg::CMD_PUT: begin
          if (item_char == tcw_pkg::NEWLINE_CHAR) begin
            col_next = 7'd0;
            row_inc  = 1'b1;
          end else begin
            put_wr = 1'b1;
            if (cur_col == LAST_COL) begin
              col_next = 7'd0;
              row_inc  = 1'b1;
            end else begin
              col_next = cur_col + 7'd1;
            end
          end
          if (row_inc) begin
            if (cur_row == LAST_ROW) ovf = 1'b1;
            else row_next = cur_row + 5'd1;
          end
        end
        tcw_pkg::CMD_CLEAR: begin
          row_next = 5'd0;
          col_next = 7'd0;
        end
        tcw_pkg::CMD_SET: begin
          row_next = item_row;
          col_next = item_col;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= 5'd0;
      cur_col <= 7'd0;
    end else begin
      cur_row <= row_next;
      cur_col <= col_next;
    end
  end

  // Select the store write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_cell = {text_color, tcw_pkg::BLANK_CHAR};
    if (ctl.init_wr) begin
      wr_en   = 1'b1;
      wr_cell = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
    end else if (ctl.clr_wr || ctl.fill_wr) begin
      wr_en = 1'b1;
    end else if (ctl.scr_wr) begin
      wr_en   = 1'b1;
      wr_cell = rdata;
    end else if (put_wr) begin
      wr_en   = 1'b1;
      wr_addr = cur_pos[ADDR_W-1:0];
      wr_cell = {text_color, item_char};
    end
  end

  // Scroll reads one row below the write pointer
  assign rd_addr = ctl.scr_rd ? (cnt + ROW_STEP) : item_pos[ADDR_W-1:0];

  // Cell store
  always_ff @(posedge clk) begin
    if (wr_en) screen[wr_addr] <= wr_cell;
    rdata <= screen[rd_addr];
  end

  // Advance the sweep counter
  assign sweep_wr = ctl.init_wr | ctl.clr_wr | ctl.scr_wr | ctl.fill_wr;

  always_ff @(posedge clk) begin
    if (rst || ctl.capture) begin
      cnt <= '0;
    end else if (sweep_wr) begin
      cnt <= cnt + ADDR_W'(1);
    end
  end

  // Text color register
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[tcw_pkg::PADDR_W-1:2] == tcw_pkg::REG_TEXT_COLOR);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcw_pkg::RESET_ATTR;
    end else if (cfg_wr) begin
      text_color <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[tcw_pkg::PADDR_W-1:2] == tcw_pkg::REG_TEXT_COLOR) begin
      prdata = {24'd0, text_color};
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      rsp_data.cursor_pos <= pos_next[10:0];
      rsp_data.cell_data  <= (item_cmd == tcw_pkg::CMD_READ) ? rdata : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Status to the controller
  assign sts.item_cmd     = item_cmd;
  assign sts.ovf          = ovf;
  assign sts.cnt_end_all  = (cnt == LAST_ADDR);
  assign sts.cnt_end_copy = (cnt == COPY_LAST);
  assign sts.out_free     = !rsp_valid || !rsp_stall;

endmodule

`default_nettype wire

### rtl/core/text_console_writer_top.sv
// Text console writer: character cell store with cursor, scroll and clear.
// Request channel (req_valid/req_stall/req_data) takes one command per
// transaction: put character, clear screen, set cursor or read cell.
// Response channel (rsp_valid/rsp_stall/rsp_data) returns one transaction per
// command: the linear cursor position after it and, for a read, the cell.
// The text color register sits at address 0 of the APB-style port.
// A read waits out the registered store read before its response loads.
// Clear and the reset fill sweep the store one cell per cycle; a put that
// scrolls reads and then writes each copied cell, and blanks the bottom row.
// One command is worked at a time; the next is taken once the response is
// in the output register.
// After reset the store is filled with blanks (attribute 0x07) with
// req_stall high; register writes are still taken.
// A stalled response holds in the output register; the block finishes the
// next command and waits for the register to free before going on.
// Depends on tcw_pkg, tcw_ctrl and tcw_dp.
`default_nettype none

module text_console_writer_top #(
  parameter int SCREEN_COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire tcw_pkg::req_t               req_data,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output tcw_pkg::rsp_t                    rsp_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  tcw_pkg::ctl_t ctl;
  tcw_pkg::sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  tcw_dp #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

`default_nettype wire

### rtl/core/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_top.
`default_nettype none

module tcw_checker #(
  parameter int SCREEN_COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::DEF_ROWS
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire tcw_pkg::rsp_t rsp_data
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;

  // Stalled response transaction holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  // Store sweep after reset keeps requests out
  a_init_stall: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken during reset fill");

  // One command at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while a command is in work");

  // Cursor stays on the screen
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CELL_COUNT > 2048) || (int'(rsp_data.cursor_pos) < CELL_COUNT))
    else $error("cursor position off screen");

endmodule

bind text_console_writer_top tcw_checker #(
  .SCREEN_COLUMNS (SCREEN_COLUMNS),
  .SCREEN_ROWS    (SCREEN_ROWS)
) u_tcw_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);

`default_nettype wire

### verif/tb_top.sv
// Self-checking bench for text_console_writer_top: directed and random commands with
// a transaction-level console predictor, random idling on both channels and APB color updates.
// Depends on tcw_pkg and the text_console_writer_top RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam logic [tcw_pkg::PADDR_W-1:0] ADDR_TEXT_COLOR =
    tcw_pkg::PADDR_W'(4 * tcw_pkg::REG_TEXT_COLOR);
  localparam logic [tcw_pkg::PADDR_W-1:0] ADDR_NO_REG = tcw_pkg::PADDR_W'(4);
  // Worst case: every item scrolls and every response waits out long stalls
  localparam int unsigned CYCLE_LIMIT = 40_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  tcw_pkg::req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  tcw_pkg::rsp_t rsp_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tcw_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Predicted console state
  logic [15:0] screen_model [CELLS];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [7:0] attr_model;
  tcw_pkg::rsp_t console_rsp_q[$];

  int errors = 0;
  int unsigned cycle_count = 0;
  int burst_left = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_tick = 0;
  tcw_pkg::rsp_t want_rsp;

  text_console_writer_top #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got 'h%0h expected 'h%0h at cycle %0d", what, got, want,
             cycle_count);
    errors++;
  endtask

  // Advance the predicted console by one command and return its response
  function automatic tcw_pkg::rsp_t console_step(input tcw_pkg::req_t item);
    tcw_pkg::rsp_t r;
    int unsigned sr;
    int unsigned sc;
    r.cell_data = '0;
    sr = (item.row > ROWS - 1) ? ROWS - 1 : item.row;
    sc = (item.col > COLS - 1) ? COLS - 1 : item.col;
    case (item.cmd)
      tcw_pkg::CMD_PUT: begin
        if (item.char_code == tcw_pkg::NEWLINE_CHAR) begin
          cur_col = 0;
          cur_row++;
        end else begin
          screen_model[cur_row * COLS + cur_col] = {attr_model, item.char_code};
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // Scroll up one row and blank the bottom row
        if (cur_row >= ROWS) begin
          for (int i = 0; i < COLS * (ROWS - 1); i++) screen_model[i] = screen_model[i + COLS];
          for (int x = 0; x < COLS; x++) begin
            screen_model[(ROWS - 1) * COLS + x] = {attr_model, tcw_pkg::BLANK_CHAR};
          end
          cur_row = ROWS - 1;
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = {attr_model, tcw_pkg::BLANK_CHAR};
        cur_row = 0;
        cur_col = 0;
      end
      tcw_pkg::CMD_SET: begin
        cur_row = sr;
        cur_col = sc;
      end
      default: begin
        r.cell_data = screen_model[sr * COLS + sc];
      end
    endcase
    r.cursor_pos = 11'(cur_row * COLS + cur_col);
    return r;
  endfunction

  function automatic tcw_pkg::req_t make_req(input tcw_pkg::cmd_t c, input logic [7:0] ch,
                                             input logic [4:0] r, input logic [6:0] col);
    tcw_pkg::req_t item;
    item.cmd = c;
    item.char_code = ch;
    item.row = r;
    item.col = col;
    return item;
  endfunction

  // Offer one transaction; when paced, insert random gaps between bursts
  task automatic send_req(input tcw_pkg::req_t item, input bit paced);
    int gap;
    if (paced) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
          req_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end
      burst_left--;
    end
    req_valid <= 1'b1;
    req_data <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    console_rsp_q.push_back(console_step(item));
  endtask

  // Drop valid and hold until every expected response has come back
  task automatic wait_drain();
    req_valid <= 1'b0;
    while (console_rsp_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // One register access: setup, access, then idle
  task automatic reg_access(input logic [tcw_pkg::PADDR_W-1:0] addr, input bit wr,
                            input logic [31:0] data, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Write the color register (or the unused slot) and read the color back
  task automatic write_color(input logic [tcw_pkg::PADDR_W-1:0] addr,
                             input logic [31:0] data);
    logic [31:0] rdata;
    reg_access(addr, 1'b1, data, rdata);
    if (addr == ADDR_TEXT_COLOR) attr_model = data[7:0];
    reg_access(ADDR_TEXT_COLOR, 1'b0, '0, rdata);
    if (rdata[7:0] !== attr_model) begin
      report_mismatch("text_color readback", int'(rdata[7:0]), int'(attr_model));
    end
  endtask

  function automatic tcw_pkg::req_t random_req();
    tcw_pkg::req_t item;
    int w;
    w = $urandom_range(0, 99);
    if (w < 55) item.cmd = tcw_pkg::CMD_PUT;
    else if (w < 57) item.cmd = tcw_pkg::CMD_CLEAR;
    else if (w < 72) item.cmd = tcw_pkg::CMD_SET;
    else item.cmd = tcw_pkg::CMD_READ;
    item.char_code = ($urandom_range(0, 99) < 3) ? tcw_pkg::NEWLINE_CHAR
                                                 : 8'($urandom_range(0, 255));
    // Keep most cursor moves in rows 0 to 15 so scrolls stay occasional
    item.row = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 15)) : 5'($urandom_range(0, 31));
    item.col = 7'($urandom_range(0, 127));
    return item;
  endfunction

  // Check each accepted response against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (console_rsp_q.size() == 0) begin
        report_mismatch("unexpected response", int'(rsp_data), 0);
      end else begin
        want_rsp = console_rsp_q.pop_front();
        if (rsp_data.cursor_pos !== want_rsp.cursor_pos)
          report_mismatch("cursor_pos", int'(rsp_data.cursor_pos), int'(want_rsp.cursor_pos));
        if (rsp_data.cell_data !== want_rsp.cell_data)
          report_mismatch("cell_data", int'(rsp_data.cell_data), int'(want_rsp.cell_data));
      end
    end
  end

  // Response stall pattern from one of four random modes, plus long hold-offs on request
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 512 == 0) stall_mode <= $urandom_range(0, 3);
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        2: rsp_stall <= 1'($urandom_range(0, 1));
        default: rsp_stall <= (stall_tick % 8 < 3);
      endcase
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d responses outstanding", console_rsp_q.size());
      $display("[text_console_writer_top] ERROR");
      $finish;
    end
  end

  task automatic test_reset_contents();
    send_req(make_req(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0), 1'b1);
    send_req(make_req(tcw_pkg::CMD_READ, 8'h00, 5'd31, 7'd127), 1'b1);
    send_req(make_req(tcw_pkg::CMD_READ, 8'h00, 5'd12, 7'd40), 1'b1);
    wait_drain();
  endtask

  task automatic test_put_wrap();
    write_color(ADDR_TEXT_COLOR, 32'hFFFF_FFFF);
    send_req(make_req(tcw_pkg::CMD_SET, 8'h00, 5'd0, 7'd78), 1'b1);
    send_req(make_req(tcw_pkg::CMD_PUT, 8'h00, 5'd0, 7'd0), 1'b1);
    send_req(make_req(tcw_pkg::CMD_PUT, 8'hFF, 5'd31, 7'd127), 1'b1);
    send_req(make_req(tcw_pkg::CMD_PUT, 8'h41, 5'd0, 7'd0), 1'b1);
    send_req(make_req(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd78), 1'b1);
    send_req(make_req(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd79), 1'b1);
    send_req(make_req(tcw_pkg::CMD_READ, 8'h00, 5'd1, 7'd0), 1'b1);
    wait_drain();
  endtask

  task automatic test_scroll();
    write_color(ADDR_TEXT_COLOR, 32'h0000_005A);
    // Saturated position lands on the last cell; the wrap scrolls
    send_req(make_req(tcw_pkg::CMD_SET, 8'h00, 5'd31, 7'd127), 1'b1);
    send_req(make_req(tcw_pkg::CMD_PUT, 8'h55, 5'd0, 7'd0), 1'b1);
    send_req(make_req(tcw_pkg::CMD_READ, 8'h00, 5'd23, 7'd79), 1'b1);
    send_req(make_req(tcw_pkg::CMD_READ, 8'h00, 5'd24, 7'd0), 1'b1);
    // Newline on the last row scrolls too
    send_req(make_req(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CHAR, 5'd0, 7'd0), 1'b1);
    send_req(make_req(tcw_pkg::CMD_READ, 8'h00, 5'd22, 7'd79), 1'b1);
    wait_drain();
  endtask

  task automatic test_clear();
    write_color(ADDR_TEXT_COLOR, 32'h0000_0000);
    send_req(make_req(tcw_pkg::CMD_SET, 8'h00, 5'd5, 7'd5), 1'b1);
    send_req(make_req(tcw_pkg::CMD_CLEAR, 8'hFF, 5'd31, 7'd127), 1'b1);
    send_req(make_req(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0), 1'b1);
    send_req(make_req(tcw_pkg::CMD_READ, 8'h00, 5'd24, 7'd79), 1'b1);
    wait_drain();
  endtask

  task automatic test_unused_register();
    // A write beyond the color register leaves the color alone
    write_color(ADDR_TEXT_COLOR, 32'h0000_00C3);
    write_color(ADDR_NO_REG, 32'hFFFF_FF3C);
    send_req(make_req(tcw_pkg::CMD_PUT, 8'h7E, 5'd0, 7'd0), 1'b1);
    send_req(make_req(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0), 1'b1);
    wait_drain();
  endtask

  task automatic test_backpressure();
    tcw_pkg::req_t item;
    hold_requests++;
    // Keep offering while the response side is held off
    for (int i = 0; i < 40; i++) begin
      item = random_req();
      if (item.cmd == tcw_pkg::CMD_CLEAR) item.cmd = tcw_pkg::CMD_PUT;
      send_req(item, 1'b0);
    end
    wait_drain();
  endtask

  task automatic test_random();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) write_color(ADDR_TEXT_COLOR, 32'h0000_0000);
      else if (p == 1) write_color(ADDR_TEXT_COLOR, 32'hFFFF_FFFF);
      else if (p % 4 == 3) write_color(ADDR_NO_REG, $urandom);
      else write_color(ADDR_TEXT_COLOR, $urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) send_req(random_req(), 1'b1);
      wait_drain();
    end
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      screen_model[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
    end
    cur_row = 0;
    cur_col = 0;
    attr_model = tcw_pkg::RESET_ATTR;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_contents();
    test_put_wrap();
    test_scroll();
    test_clear();
    test_unused_register();
    test_backpressure();
    test_random();
    test_backpressure();

    wait_drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("[text_console_writer_top] OK");
    end else begin
      $display("[text_console_writer_top] ERROR");
    end
    $finish;
  end

endmodule
